@@ rtl/grid_astar_search_core_defines.svh @@
// Assertion macros for the grid A* search core.
// Used by grid_astar_search_core.sv; no other dependencies.
`ifndef GRID_ASTAR_SEARCH_CORE_DEFINES_SVH
`define GRID_ASTAR_SEARCH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define GAS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GAS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GAS_ASSERT(label, clk, rst_n, prop, msg)
`define GAS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/gas_pkg.sv @@
// Package for the grid A* search core: sizes, cell kinds, status codes, FSM states.
// No dependencies.
package gas_pkg;
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int Cells     = MaxWidth * MaxHeight;
  localparam int AddrW     = $clog2(Cells);
  localparam int XW        = $clog2(MaxWidth);
  localparam int YW        = $clog2(MaxHeight);
  localparam int CostW     = 12;
  localparam int CountW    = 13;
  localparam int DimW      = 7;

  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_WALL  = 2'd1,
    KIND_START = 2'd2,
    KIND_GOAL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_REACHED = 2'd0,
    ST_NOPATH  = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLEAR,
    S_NB_ADDR,
    S_NB_READ,
    S_NB_WRITE,
    S_SCAN_ADDR,
    S_SCAN,
    S_SCAN_LAST,
    S_POP,
    S_DONE
  } state_t;
endpackage

@@ rtl/grid_astar_search_core.sv @@
// Grid A* search core: loads a grid one cell per beat, then searches start to goal.
// The last cell starts a search (or a missing result if start or goal is absent):
// the node memory is cleared, then each expansion updates the neighbors and does
// a full open-set scan through the node memory, one entry a cycle. Input stalls
// during the search and while a result waits. Reset (rst_n, sync, active low)
// clears control state; the grid memories are undefined until written.
`include "grid_astar_search_core_defines.svh"
module grid_astar_search_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cell_kind,
  input  logic        in_last_cell,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [11:0] out_path_cost,
  output logic [12:0] out_expanded_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam int AW = gas_pkg::AddrW;
  localparam int XW = gas_pkg::XW;
  localparam int YW = gas_pkg::YW;
  localparam int CW = gas_pkg::CostW;
  localparam int NW = gas_pkg::CountW;
  localparam int DW = gas_pkg::DimW;

  // node memory entry: open, closed, cost, stamp
  localparam int EW = 2 + CW + NW;

  logic [1:0]    cell_mem [gas_pkg::Cells];
  logic [EW-1:0] node_mem [gas_pkg::Cells];

  gas_pkg::state_t state_r, state_nxt;

  logic [DW-1:0] width_r, height_r;
  logic [AW:0]   load_idx_r, load_idx_nxt;
  logic [AW-1:0] start_r, start_nxt, goal_r, goal_nxt;
  logic          start_seen_r, start_seen_nxt, goal_seen_r, goal_seen_nxt;
  logic [AW:0]   idx_r, idx_nxt;
  logic [XW-1:0] cx_r, cx_nxt, ix_r, ix_nxt;
  logic [YW-1:0] cy_r, cy_nxt, iy_r, iy_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [CW-1:0] curg_r, curg_nxt;
  logic [NW-1:0] open_cnt_r, open_cnt_nxt, closed_cnt_r, closed_cnt_nxt;
  logic [NW-1:0] ins_r, ins_nxt;
  logic [AW-1:0] nb_r, nb_nxt, best_r, best_nxt;
  logic [CW+XW+YW:0] bestf_r, bestf_nxt;
  logic [NW-1:0] bests_r, bests_nxt;
  logic          found_r, found_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [CW-1:0] cost_r, cost_nxt;
  logic [NW-1:0] count_r, count_nxt;

  // cost and coordinates of the best entry, captured while scanning
  logic [CW-1:0] bestf_cost_r, bestf_cost_nxt;
  logic [XW-1:0] bx_r, bx_nxt;
  logic [YW-1:0] by_r, by_nxt;

  // memory ports
  logic          cm_we;
  logic [AW-1:0] cm_waddr, cm_raddr;
  logic [1:0]    cm_wdata, cm_rdata_r;
  logic          nm_we;
  logic [AW-1:0] nm_waddr, nm_raddr;
  logic [EW-1:0] nm_wdata, nm_rdata_r;

  always_ff @(posedge clk) begin
    if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
    cm_rdata_r <= cell_mem[cm_raddr];
  end
  always_ff @(posedge clk) begin
    if (nm_we) node_mem[nm_waddr] <= nm_wdata;
    nm_rdata_r <= node_mem[nm_raddr];
  end

  // effective dimensions
  logic [DW-1:0] w_eff, h_eff;
  logic [2*DW-1:0] total;
  always_comb begin
    w_eff = (width_r == '0) ? DW'(1) : (width_r > DW'(gas_pkg::MaxWidth))
            ? DW'(gas_pkg::MaxWidth) : width_r;
    h_eff = (height_r == '0) ? DW'(1) : (height_r > DW'(gas_pkg::MaxHeight))
            ? DW'(gas_pkg::MaxHeight) : height_r;
    total = w_eff * h_eff;
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall  = (state_r != gas_pkg::S_LOAD) || out_valid_r;
  assign cfg_ready = (state_r == gas_pkg::S_LOAD);
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_path_cost = cost_r;
  assign out_expanded_count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(gas_pkg::MaxWidth);
      height_r <= DW'(gas_pkg::MaxHeight);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == gas_pkg::CFG_WIDTH) width_r <= cfg_data;
      else height_r <= cfg_data;
    end
  end

  // goal coordinates, held as row/col registers (one divide-free walk per search)
  logic [XW-1:0] gx_r, gx_nxt;
  logic [YW-1:0] gy_r, gy_nxt;

  // cell address from coordinates (narrow multiply)
  function automatic logic [AW-1:0] xy_addr(logic [YW-1:0] y, logic [XW-1:0] x,
                                            logic [DW-1:0] w);
    logic [AW+DW-1:0] p;
    p = y * w + x;
    return p[AW-1:0];
  endfunction

  function automatic logic [CW+XW+YW:0] fval(logic [CW-1:0] g, logic [XW-1:0] x,
                                             logic [YW-1:0] y, logic [XW-1:0] gx,
                                             logic [YW-1:0] gy);
    logic [XW-1:0] dx;
    logic [YW-1:0] dy;
    dx = (x > gx) ? x - gx : gx - x;
    dy = (y > gy) ? y - gy : gy - y;
    return (CW+XW+YW+1)'(g) + (CW+XW+YW+1)'(dx) + (CW+XW+YW+1)'(dy);
  endfunction

  // neighbor coordinates for the current direction
  logic          nb_ok;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  always_comb begin
    nx = cx_r;
    ny = cy_r;
    nb_ok = 1'b1;
    case (dir_r)
      2'd0: begin nb_ok = (cx_r != '0); nx = cx_r - XW'(1); end
      2'd1: begin nb_ok = (cy_r != '0); ny = cy_r - YW'(1); end
      2'd2: begin
        nb_ok = ({1'b0, cx_r} + (XW+1)'(1) < (XW+1)'(w_eff));
        nx = cx_r + XW'(1);
      end
      default: begin
        nb_ok = ({1'b0, cy_r} + (YW+1)'(1) < (YW+1)'(h_eff));
        ny = cy_r + YW'(1);
      end
    endcase
  end

  logic          e_open, e_closed;
  logic [CW-1:0] e_cost;
  logic [NW-1:0] e_stamp;
  assign {e_open, e_closed, e_cost, e_stamp} = nm_rdata_r;
  logic [CW+XW+YW:0] f_cur;
  assign f_cur = fval(e_cost, ix_r, iy_r, gx_r, gy_r);

  always_comb begin
    state_nxt = state_r;
    load_idx_nxt = load_idx_r;
    start_nxt = start_r; goal_nxt = goal_r;
    start_seen_nxt = start_seen_r; goal_seen_nxt = goal_seen_r;
    idx_nxt = idx_r; cx_nxt = cx_r; cy_nxt = cy_r; ix_nxt = ix_r; iy_nxt = iy_r;
    dir_nxt = dir_r; curg_nxt = curg_r;
    open_cnt_nxt = open_cnt_r; closed_cnt_nxt = closed_cnt_r; ins_nxt = ins_r;
    nb_nxt = nb_r; best_nxt = best_r; bestf_nxt = bestf_r; bests_nxt = bests_r;
    found_nxt = found_r; gx_nxt = gx_r; gy_nxt = gy_r;
    bestf_cost_nxt = bestf_cost_r; bx_nxt = bx_r; by_nxt = by_r;
    out_valid_nxt = out_valid_r && !out_acc;
    status_nxt = status_r; cost_nxt = cost_r; count_nxt = count_r;
    cm_we = 1'b0; cm_waddr = load_idx_r[AW-1:0]; cm_wdata = in_cell_kind;
    cm_raddr = nb_r;
    nm_we = 1'b0; nm_waddr = nb_r; nm_wdata = '0; nm_raddr = idx_r[AW-1:0];
    case (state_r)
      gas_pkg::S_LOAD: begin
        if (in_acc) begin
          if ({{(2*DW-AW-1){1'b0}}, load_idx_r} < total) begin
            cm_we = 1'b1;
            if (in_cell_kind == gas_pkg::KIND_START && !start_seen_r) begin
              start_seen_nxt = 1'b1; start_nxt = load_idx_r[AW-1:0];
            end
            if (in_cell_kind == gas_pkg::KIND_GOAL && !goal_seen_r) begin
              goal_seen_nxt = 1'b1; goal_nxt = load_idx_r[AW-1:0];
            end
            load_idx_nxt = load_idx_r + (AW+1)'(1);
          end
          if (in_last_cell) begin
            // decide missing using the post-load flags
            if (!start_seen_nxt || !goal_seen_nxt ||
                (2*DW)'(start_nxt) >= total || (2*DW)'(goal_nxt) >= total) begin
              out_valid_nxt = 1'b1;
              status_nxt = gas_pkg::ST_MISSING; cost_nxt = '0; count_nxt = '0;
              load_idx_nxt = '0; start_seen_nxt = 1'b0; goal_seen_nxt = 1'b0;
            end else begin
              state_nxt = gas_pkg::S_CLEAR;
              idx_nxt = '0; ix_nxt = '0; iy_nxt = '0;
              cx_nxt = '0; cy_nxt = '0; gx_nxt = '0; gy_nxt = '0;
            end
          end
        end
      end
      gas_pkg::S_CLEAR: begin
        // sweep node memory; walk coordinates to find start and goal x/y
        nm_we = 1'b1; nm_waddr = idx_r[AW-1:0];
        nm_wdata = (idx_r[AW-1:0] == start_r) ? {1'b0, 1'b1, {CW{1'b0}}, {NW{1'b0}}} : '0;
        if (idx_r[AW-1:0] == start_r) begin cx_nxt = ix_r; cy_nxt = iy_r; end
        if (idx_r[AW-1:0] == goal_r) begin gx_nxt = ix_r; gy_nxt = iy_r; end
        if ({1'b0, ix_r} + (XW+1)'(1) >= (XW+1)'(w_eff)) begin
          ix_nxt = '0; iy_nxt = iy_r + YW'(1);
        end else ix_nxt = ix_r + XW'(1);
        idx_nxt = idx_r + (AW+1)'(1);
        if (idx_r == (AW+1)'(gas_pkg::Cells - 1)) begin
          state_nxt = gas_pkg::S_NB_ADDR;
          open_cnt_nxt = '0; ins_nxt = '0; closed_cnt_nxt = NW'(1);
          curg_nxt = '0; dir_nxt = '0;
        end
      end
      gas_pkg::S_NB_ADDR: begin
        nb_nxt = xy_addr(ny, nx, w_eff);
        if (nb_ok) state_nxt = gas_pkg::S_NB_READ;
        else if (dir_r == 2'd3) state_nxt = gas_pkg::S_SCAN_ADDR;
        else dir_nxt = dir_r + 2'd1;
        cm_raddr = xy_addr(ny, nx, w_eff);
        nm_raddr = xy_addr(ny, nx, w_eff);
      end
      gas_pkg::S_NB_READ: begin
        // the read is registered; hold the neighbor address
        nm_raddr = nb_r;
        state_nxt = gas_pkg::S_NB_WRITE;
      end
      gas_pkg::S_NB_WRITE: begin
        if (!((nb_r < load_idx_r[AW-1:0] || load_idx_r[AW]) &&
              cm_rdata_r == gas_pkg::KIND_WALL) && !e_open && !e_closed) begin
          nm_we = 1'b1;
          nm_wdata = {1'b1, 1'b0,
                      (curg_r == {CW{1'b1}}) ? curg_r : curg_r + CW'(1), ins_r};
          ins_nxt = ins_r + NW'(1);
          open_cnt_nxt = open_cnt_r + NW'(1);
        end
        if (dir_r == 2'd3) state_nxt = gas_pkg::S_SCAN_ADDR;
        else begin dir_nxt = dir_r + 2'd1; state_nxt = gas_pkg::S_NB_ADDR; end
      end
      gas_pkg::S_SCAN_ADDR: begin
        if (open_cnt_r == '0) begin
          out_valid_nxt = 1'b1; status_nxt = gas_pkg::ST_NOPATH; cost_nxt = '0;
          count_nxt = closed_cnt_r;
          state_nxt = gas_pkg::S_DONE;
        end else begin
          idx_nxt = '0; ix_nxt = '0; iy_nxt = '0; found_nxt = 1'b0;
          nm_raddr = '0;
          state_nxt = gas_pkg::S_SCAN;
        end
      end
      gas_pkg::S_SCAN: begin
        // data for idx_r arrives now; issue read of the next entry
        nm_raddr = idx_r[AW-1:0] + AW'(1);
        if (e_open && (!found_r || f_cur < bestf_r ||
                       (f_cur == bestf_r && e_stamp < bests_r))) begin
          found_nxt = 1'b1; best_nxt = idx_r[AW-1:0];
          bestf_nxt = f_cur; bests_nxt = e_stamp;
          bestf_cost_nxt = e_cost; bx_nxt = ix_r; by_nxt = iy_r;
        end
        if ({1'b0, ix_r} + (XW+1)'(1) >= (XW+1)'(w_eff)) begin
          ix_nxt = '0; iy_nxt = iy_r + YW'(1);
        end else ix_nxt = ix_r + XW'(1);
        idx_nxt = idx_r + (AW+1)'(1);
        if ((2*DW)'(idx_r) + (2*DW)'(1) >= total) state_nxt = gas_pkg::S_POP;
      end
      gas_pkg::S_POP: begin
        // close the best entry; finish if it is the goal, else expand from it
        cx_nxt = bx_r; cy_nxt = by_r;
        nm_we = 1'b1; nm_waddr = best_r;
        nm_wdata = {1'b0, 1'b1, bestf_cost_r, bests_r};
        curg_nxt = bestf_cost_r;
        open_cnt_nxt = open_cnt_r - NW'(1);
        closed_cnt_nxt = (closed_cnt_r == {NW{1'b1}}) ? closed_cnt_r
                         : closed_cnt_r + NW'(1);
        if (best_r == goal_r) begin
          out_valid_nxt = 1'b1; status_nxt = gas_pkg::ST_REACHED;
          cost_nxt = bestf_cost_r;
          count_nxt = (closed_cnt_r == {NW{1'b1}}) ? closed_cnt_r
                      : closed_cnt_r + NW'(1);
          state_nxt = gas_pkg::S_DONE;
        end else begin
          dir_nxt = '0; state_nxt = gas_pkg::S_NB_ADDR;
        end
      end
      gas_pkg::S_DONE: begin
        load_idx_nxt = '0; start_seen_nxt = 1'b0; goal_seen_nxt = 1'b0;
        state_nxt = gas_pkg::S_LOAD;
      end
      default: state_nxt = gas_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gas_pkg::S_LOAD;
      load_idx_r <= '0; start_r <= '0; goal_r <= '0;
      start_seen_r <= 1'b0; goal_seen_r <= 1'b0;
      open_cnt_r <= '0; closed_cnt_r <= '0; ins_r <= '0;
      out_valid_r <= 1'b0; found_r <= 1'b0; dir_r <= '0;
    end else begin
      state_r <= state_nxt;
      load_idx_r <= load_idx_nxt; start_r <= start_nxt; goal_r <= goal_nxt;
      start_seen_r <= start_seen_nxt; goal_seen_r <= goal_seen_nxt;
      open_cnt_r <= open_cnt_nxt; closed_cnt_r <= closed_cnt_nxt; ins_r <= ins_nxt;
      out_valid_r <= out_valid_nxt; found_r <= found_nxt; dir_r <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt; ix_r <= ix_nxt; iy_r <= iy_nxt;
    curg_r <= curg_nxt; nb_r <= nb_nxt; best_r <= best_nxt;
    bestf_r <= bestf_nxt; bests_r <= bests_nxt; gx_r <= gx_nxt; gy_r <= gy_nxt;
    bestf_cost_r <= bestf_cost_nxt; bx_r <= bx_nxt; by_r <= by_nxt;
    status_r <= status_nxt; cost_r <= cost_nxt; count_r <= count_nxt;
  end

  `GAS_ASSERT(a_stall_busy, clk, rst_n, (state_r != gas_pkg::S_LOAD) |-> in_stall,
              "input taken during search")
  `GAS_ASSERT(a_out_hold, clk, rst_n,
              (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_status)),
              "result dropped while stalled")
  `GAS_ASSERT(a_open_nz, clk, rst_n,
              (state_r == gas_pkg::S_POP) |-> (open_cnt_r != '0 && found_r),
              "pop with empty open set")
endmodule
